>>> sv/rpft_pkg.sv
// ----------------------------------------------------------------------------
// rpft_pkg
// Shared widths, reset values, register indexes and the request and status
// types between the tracker and its iterative arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rpft_pkg;

  localparam int unsigned THR_W      = 16;
  localparam int unsigned FILL_W     = 13;
  localparam int unsigned CYC_W      = 24;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SUM_W      = 29;
  localparam int unsigned RSS_W      = 16;
  localparam int unsigned SEQ_W      = 10;
  localparam int unsigned FB_W       = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SEQ_W-1:0]  SEQ_WRAP      = 10'd1000;
  localparam logic [THR_W-1:0]  THR_RESET     = 16'd1;
  localparam logic [FILL_W-1:0] PKT_LEN_RESET = 13'd800;
  localparam logic [CYC_W-1:0]  CYC_LEN_RESET = 24'd10000;
  localparam logic [TIME_W-1:0] DELAY_RESET   = 32'd22500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_PKT_LEN   = 2'd1,
    CFG_CYC_LEN   = 2'd2,
    CFG_DELAY     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_MAG = 1'b0,
    OP_DIV = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

endpackage

`default_nettype wire

>>> sv/rpft_arith.sv
// ----------------------------------------------------------------------------
// rpft_arith
// Iterative arithmetic unit: magnitude floor(sqrt(a*a + b*b)) through one
// squarer and a digit-by-digit root, and an unsigned restoring divide; both
// run on one shared compare-and-subtract stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpft_arith #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire rpft_pkg::arith_req_t                 req_i,
  input  wire logic [SAMPLE_BITS-1:0]               a_i,
  input  wire logic [SAMPLE_BITS-1:0]               b_i,
  input  wire logic [rpft_pkg::SUM_W-1:0]           dividend_i,
  input  wire logic [rpft_pkg::FILL_W-1:0]          divisor_i,
  output rpft_pkg::arith_stat_t                     stat_o,
  output logic [SAMPLE_BITS-1:0]                    mag_o,
  output logic [rpft_pkg::SUM_W-1:0]                quot_o
);
  import rpft_pkg::*;

  localparam int unsigned RAD_W    = 2 * SAMPLE_BITS;
  localparam int unsigned ALU_W    = (SAMPLE_BITS + 2 > FILL_W + 1) ? SAMPLE_BITS + 2
                                                                    : FILL_W + 1;
  localparam int unsigned STEP_MAX = (SAMPLE_BITS > SUM_W) ? SAMPLE_BITS : SUM_W;
  localparam int unsigned CNT_W    = $clog2(STEP_MAX);

  typedef enum logic [2:0] {
    A_IDLE,
    A_SQ_A,
    A_SQ_B,
    A_ROOT,
    A_DIV
  } a_state_e;

  a_state_e                state_q;
  logic                    done_q;
  logic [SAMPLE_BITS-1:0]  a_q;
  logic [SAMPLE_BITS-1:0]  b_q;
  logic [RAD_W-1:0]        rad_q;
  logic [SAMPLE_BITS-1:0]  root_q;
  logic [ALU_W-1:0]        rem_q;
  logic [SUM_W-1:0]        div_q;
  logic [FILL_W-1:0]       divisor_q;
  logic [CNT_W-1:0]        cnt_q;

  logic [SAMPLE_BITS-1:0]  mul_op;
  logic [RAD_W-1:0]        prod;
  logic [ALU_W-1:0]        rem_shift;
  logic [ALU_W-1:0]        sub_b;
  logic [ALU_W:0]          diff;
  logic                    ge;
  logic [ALU_W-1:0]        rem_next;

  assign mul_op = (state_q == A_SQ_A) ? a_q : b_q;
  assign prod   = {{SAMPLE_BITS{1'b0}}, mul_op} * {{SAMPLE_BITS{1'b0}}, mul_op};

  // shared compare-and-subtract: root trial or divisor against the shifted remainder
  always_comb begin
    if (state_q == A_DIV) begin
      rem_shift = {rem_q[ALU_W-2:0], div_q[SUM_W-1]};
      sub_b     = ALU_W'(divisor_q);
    end else begin
      rem_shift = {rem_q[ALU_W-3:0], rad_q[RAD_W-1 -: 2]};
      sub_b     = ALU_W'({root_q, 2'b01});
    end
  end

  assign diff     = {1'b0, rem_shift} - {1'b0, sub_b};
  assign ge       = ~diff[ALU_W];
  assign rem_next = ge ? diff[ALU_W-1:0] : rem_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= A_IDLE;
      done_q    <= 1'b0;
      a_q       <= '0;
      b_q       <= '0;
      rad_q     <= '0;
      root_q    <= '0;
      rem_q     <= '0;
      div_q     <= '0;
      divisor_q <= '0;
      cnt_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            if (req_i.op == OP_MAG) begin
              a_q     <= a_i;
              b_q     <= b_i;
              state_q <= A_SQ_A;
            end else begin
              div_q     <= dividend_i;
              divisor_q <= divisor_i;
              rem_q     <= '0;
              cnt_q     <= CNT_W'(SUM_W - 1);
              state_q   <= A_DIV;
            end
          end
        end
        A_SQ_A: begin
          rad_q   <= prod;
          state_q <= A_SQ_B;
        end
        A_SQ_B: begin
          rad_q   <= rad_q + prod;
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= CNT_W'(SAMPLE_BITS - 1);
          state_q <= A_ROOT;
        end
        A_ROOT: begin
          rem_q  <= rem_next;
          root_q <= {root_q[SAMPLE_BITS-2:0], ge};
          rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
          if (cnt_q == '0) begin
            done_q  <= 1'b1;
            state_q <= A_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        A_DIV: begin
          rem_q <= rem_next;
          div_q <= {div_q[SUM_W-2:0], ge};
          if (cnt_q == '0) begin
            done_q  <= 1'b1;
            state_q <= A_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign stat_o.busy = (state_q != A_IDLE);
  assign stat_o.done = done_q;
  assign mag_o       = root_q;
  assign quot_o      = div_q;

endmodule

`default_nettype wire

>>> sv/rss_peak_feedback_tracker.sv
// ----------------------------------------------------------------------------
// rss_peak_feedback_tracker
// Tracks packet RSS from I/Q samples and forms a signed peak feedback value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one I/Q sample per request.
//   Output channel (out_valid_o / out_stall_i) carries feedback_value_o, at
//   most one per sample: every cycle_length samples the held value is sent,
//   registered the cycle after the sample is taken.
//   Each sample takes two passes through one squarer and one root digit per
//   cycle in the shared unit. A sample that completes a packet adds the
//   bit-serial average divide on the same compare-and-subtract stage.
//   One sample at a time: in_stall_o is high while a sample is in work, and
//   also when a value is waiting on a stalled output and the next sample
//   would send another one. A waiting value does not otherwise hold input.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i only
//   while idle; the user must keep to this, the block does not enforce it.
//   Reset restores the register defaults and clears all tracking state;
//   the output channel comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_peak_feedback_tracker #(
  parameter int unsigned HISTORY_DEPTH = 4,
  parameter int unsigned SAMPLE_BITS   = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [rpft_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [rpft_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]          i_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0]          q_sample_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [rpft_pkg::FB_W-1:0]            feedback_value_o
);
  import rpft_pkg::*;

  localparam int unsigned CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAG,
    ST_DIVS,
    ST_DIV
  } state_e;

  state_e               state_q;
  logic [THR_W-1:0]     threshold_q;
  logic [FILL_W-1:0]    pkt_len_q;
  logic [CYC_W-1:0]     cyc_len_q;
  logic [TIME_W-1:0]    delay_q;
  logic [TIME_W-1:0]    sample_cnt_q;
  logic [CYC_W-1:0]     cycle_cnt_q;
  logic [FILL_W-1:0]    fill_q;
  logic [SUM_W-1:0]     sum_q;
  logic [TIME_W-1:0]    last_meas_q;
  logic [RSS_W-1:0]     prev_rss_q;
  logic [RSS_W-1:0]     hist_q [HISTORY_DEPTH];
  logic [SEQ_W-1:0]     seq_q;
  logic [FB_W-1:0]      held_fb_q;
  logic                 out_valid_q;
  logic [FB_W-1:0]      out_fb_q;

  arith_req_t             arith_req;
  arith_stat_t            arith_stat;
  logic [SAMPLE_BITS-1:0] abs_i;
  logic [SAMPLE_BITS-1:0] abs_q;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SUM_W-1:0]       quot;

  logic [CYC_W-1:0]     cyc_inc;
  logic                 emit_next;
  logic                 accept;
  logic                 mag_gt;
  logic [SUM_W:0]       sum_add;
  logic [SUM_W-1:0]     sum_sat;
  logic [FILL_W-1:0]    fill_inc;
  logic [RSS_W-1:0]     avg;
  logic [TIME_W-1:0]    gap;
  logic                 above_all;
  logic [SEQ_W-1:0]     seq_next;
  logic [FB_W-1:0]      fb_new;

  assign cyc_inc    = cycle_cnt_q + 1'b1;
  assign emit_next  = (cyc_inc >= cyc_len_q);
  assign in_stall_o = (state_q != ST_IDLE) | (out_valid_q & emit_next);
  assign accept     = in_valid_i & ~in_stall_o;

  assign abs_i = i_sample_i[SAMPLE_BITS-1] ? (~$unsigned(i_sample_i) + 1'b1)
                                           : $unsigned(i_sample_i);
  assign abs_q = q_sample_i[SAMPLE_BITS-1] ? (~$unsigned(q_sample_i) + 1'b1)
                                           : $unsigned(q_sample_i);

  assign arith_req.start = accept | (state_q == ST_DIVS);
  assign arith_req.op    = (state_q == ST_DIVS) ? OP_DIV : OP_MAG;

  rpft_arith #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_arith (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (arith_req),
    .a_i        (abs_i),
    .b_i        (abs_q),
    .dividend_i (sum_q),
    .divisor_i  (pkt_len_q),
    .stat_o     (arith_stat),
    .mag_o      (mag),
    .quot_o     (quot)
  );

  assign mag_gt   = CMP_W'(mag) > CMP_W'(threshold_q);
  assign sum_add  = {1'b0, sum_q} + (SUM_W + 1)'(mag);
  assign sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign fill_inc = fill_q + 1'b1;

  // average saturates to the rss width
  assign avg      = (|quot[SUM_W-1:RSS_W]) ? '1 : quot[RSS_W-1:0];
  assign gap      = sample_cnt_q - last_meas_q;
  assign seq_next = (seq_q < SEQ_WRAP) ? seq_q + 1'b1 : SEQ_W'(1);

  always_comb begin
    above_all = 1'b1;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      above_all = above_all & (avg > hist_q[k]);
    end
  end

  assign fb_new = above_all ? {1'b0, seq_next} : (FB_W'(0) - {1'b0, seq_next});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      threshold_q  <= THR_RESET;
      pkt_len_q    <= PKT_LEN_RESET;
      cyc_len_q    <= CYC_LEN_RESET;
      delay_q      <= DELAY_RESET;
      sample_cnt_q <= '0;
      cycle_cnt_q  <= '0;
      fill_q       <= '0;
      sum_q        <= '0;
      last_meas_q  <= '0;
      prev_rss_q   <= '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_q[k] <= '0;
      end
      seq_q        <= '0;
      held_fb_q    <= '0;
      out_valid_q  <= 1'b0;
      out_fb_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_THRESHOLD: threshold_q <= cfg_data_i[THR_W-1:0];
          CFG_PKT_LEN:   pkt_len_q   <= cfg_data_i[FILL_W-1:0];
          CFG_CYC_LEN:   cyc_len_q   <= cfg_data_i[CYC_W-1:0];
          CFG_DELAY:     delay_q     <= cfg_data_i[TIME_W-1:0];
          default:       threshold_q <= threshold_q;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            sample_cnt_q <= sample_cnt_q + 1'b1;
            // held value goes out before this sample updates anything
            if (emit_next) begin
              cycle_cnt_q <= '0;
              out_valid_q <= 1'b1;
              out_fb_q    <= held_fb_q;
            end else begin
              cycle_cnt_q <= cyc_inc;
            end
            state_q <= ST_MAG;
          end
        end
        ST_MAG: begin
          if (arith_stat.done) begin
            state_q <= ST_IDLE;
            if (mag_gt) begin
              sum_q <= sum_sat;
              if (fill_q < pkt_len_q) begin
                fill_q <= fill_inc;
                if (fill_inc == pkt_len_q) begin
                  state_q <= ST_DIVS;
                end
              end
            end else begin
              fill_q <= '0;
              sum_q  <= '0;
            end
          end
        end
        ST_DIVS: state_q <= ST_DIV;
        ST_DIV: begin
          if (arith_stat.done) begin
            last_meas_q <= sample_cnt_q;
            prev_rss_q  <= avg;
            if ((gap < delay_q) && (avg > prev_rss_q)) begin
              seq_q     <= seq_next;
              held_fb_q <= fb_new;
              for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
                hist_q[k] <= hist_q[k-1];
              end
              hist_q[0] <= avg;
              sum_q     <= '0;
              fill_q    <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign feedback_value_o = $signed(out_fb_q);

  a_stall_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_stat.busy |-> in_stall_o)
    else $error("sample request taken while arithmetic unit busy");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_stat.done |-> (state_q == ST_MAG || state_q == ST_DIV))
    else $error("arithmetic result with no sample waiting on it");

  a_seq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q <= SEQ_WRAP)
    else $error("packet sequence past wrap point");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit_next) |-> !out_valid_q)
    else $error("feedback request would overwrite a pending one");

endmodule

`default_nettype wire
